// File: rtl/sra_k_pkg.sv
// ----------------------------------------------------------------------------
// sra_k_pkg
// Shared types and constants of the super-random generator: datapath
// operation codes, operand selects and the controller/datapath interface.
// ----------------------------------------------------------------------------
package sra_k_pkg;

    localparam int W_X = 34;
    localparam int W_P = 68;
    localparam int W_BCD = 80;
    localparam int W_DIG = 40;

    localparam logic [W_X-1:0] C_E5    = 34'd100000;
    localparam logic [W_X-1:0] C_E8    = 34'd100000000;
    localparam logic [W_X-1:0] C_E9    = 34'd1000000000;
    localparam logic [W_X-1:0] C_5E9   = 34'd5000000000;
    localparam logic [W_X-1:0] C_E10   = 34'd10000000000;
    localparam logic [W_X-1:0] C_K     = 34'd1001001001;
    localparam logic [W_X-1:0] C_OFS   = 34'd9814055677;
    localparam logic [W_X-1:0] C_99999 = 34'd99999;

    typedef logic [4:0] t_op;

    localparam t_op OP_NOP       = 5'd0;
    localparam t_op OP_LOAD      = 5'd1;
    localparam t_op OP_ADD5E9    = 5'd2;
    localparam t_op OP_STEP6     = 5'd3;
    localparam t_op OP_SUB99999  = 5'd4;
    localparam t_op OP_MUL10     = 5'd5;
    localparam t_op OP_MUL_INIT  = 5'd6;
    localparam t_op OP_MUL_STEP  = 5'd7;
    localparam t_op OP_QCVT_INIT = 5'd8;
    localparam t_op OP_PICK      = 5'd9;
    localparam t_op OP_TAKE_P99  = 5'd11;
    localparam t_op OP_CVT_INIT  = 5'd12;
    localparam t_op OP_CVT_STEP  = 5'd13;
    localparam t_op OP_SWAP      = 5'd14;
    localparam t_op OP_DECD      = 5'd15;
    localparam t_op OP_HORN      = 5'd16;

    typedef logic [1:0] t_msel;

    localparam t_msel MS_SQ   = 2'd0;
    localparam t_msel MS_SQM1 = 2'd1;
    localparam t_msel MS_K    = 2'd2;

    localparam logic DS_E5  = 1'b0;
    localparam logic DS_E10 = 1'b1;

    typedef struct packed {
        t_op   op;
        t_msel msel;
        logic  dsel;
    } t_cmd;

    typedef struct packed {
        logic       lt_e5;
        logic       lt_e9;
        logic       zero;
        logic [3:0] lead;
        logic [3:0] dig8;
    } t_status;

endpackage

// File: rtl/sra_k_datapath.sv
// ----------------------------------------------------------------------------
// sra_k_datapath
// Value register with a bit-serial multiplier, a binary-to-decimal converter
// for values and products, and a decimal-to-binary accumulator.
// ----------------------------------------------------------------------------
module sra_k_datapath
    import sra_k_pkg::*;
(
    input  logic           i_clk,
    input  logic [W_X-1:0] i_start_value,
    input  t_cmd           i_cmd,
    output t_status        o_status,
    output logic [W_X-1:0] o_x
);

    logic [W_X-1:0]   r_x;
    logic [W_P-1:0]   r_p;
    logic [W_P-1:0]   r_ma;
    logic [W_X-1:0]   r_mb;
    logic [W_P-1:0]   r_sh;
    logic [W_BCD-1:0] r_bcd;

    logic [W_BCD-1:0] bcd_adj;
    logic [W_DIG-1:0] bcd_dec;
    logic [W_X-1:0]   x_mul10;

    always_comb begin
        for (int i = 0; i < W_BCD / 4; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ?
                                r_bcd[4*i +: 4] + 4'd3 : r_bcd[4*i +: 4];
        end
        for (int i = 0; i < W_DIG / 4; i++) begin
            bcd_dec[4*i +: 4] = (r_bcd[4*i +: 4] != 4'd0) ?
                                r_bcd[4*i +: 4] - 4'd1 : 4'd0;
        end
    end

    assign x_mul10 = {r_x[W_X-4:0], 3'b000} + {r_x[W_X-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_NOP: begin
            end
            OP_LOAD: begin
                r_x <= (i_start_value >= C_E10) ? i_start_value - C_E10 : i_start_value;
            end
            OP_ADD5E9: begin
                if (r_x < C_5E9) begin
                    r_x <= r_x + C_5E9;
                end
            end
            OP_STEP6: begin
                r_x <= (r_x < C_E8) ? r_x + C_OFS : C_E10 - r_x;
            end
            OP_SUB99999: begin
                r_x <= r_x - C_99999;
            end
            OP_MUL10: begin
                r_x <= x_mul10;
            end
            OP_MUL_INIT: begin
                r_p  <= '0;
                r_ma <= {{(W_P-W_X){1'b0}}, r_x};
                case (i_cmd.msel)
                    MS_SQM1: r_mb <= r_x - 34'd1;
                    MS_K:    r_mb <= C_K;
                    default: r_mb <= r_x;
                endcase
            end
            OP_MUL_STEP: begin
                if (r_mb[0]) begin
                    r_p <= r_p + r_ma;
                end
                r_ma <= {r_ma[W_P-2:0], 1'b0};
                r_mb <= {1'b0, r_mb[W_X-1:1]};
            end
            OP_QCVT_INIT: begin
                r_sh  <= r_p;
                r_bcd <= '0;
            end
            OP_PICK: begin
                r_bcd <= (i_cmd.dsel == DS_E5) ? {20'd0, r_bcd[W_BCD-1:20]} : r_bcd;
                r_x   <= '0;
            end
            OP_TAKE_P99: begin
                r_x <= r_p[W_X-1:0] + C_99999;
            end
            OP_CVT_INIT: begin
                r_sh  <= {r_x, {(W_P-W_X){1'b0}}};
                r_bcd <= '0;
            end
            OP_CVT_STEP: begin
                r_bcd <= {bcd_adj[W_BCD-2:0], r_sh[W_P-1]};
                r_sh  <= {r_sh[W_P-2:0], 1'b0};
            end
            OP_SWAP: begin
                r_bcd <= {{(W_BCD-W_DIG){1'b0}}, r_bcd[19:0], r_bcd[39:20]};
                r_x   <= '0;
            end
            OP_DECD: begin
                r_bcd <= {{(W_BCD-W_DIG){1'b0}}, bcd_dec};
                r_x   <= '0;
            end
            OP_HORN: begin
                r_x   <= x_mul10 + {30'd0, r_bcd[39:36]};
                r_bcd <= {r_bcd[W_BCD-5:0], 4'd0};
            end
            default: begin
            end
        endcase
    end

    assign o_status.lt_e5 = r_x < C_E5;
    assign o_status.lt_e9 = r_x < C_E9;
    assign o_status.zero  = r_x == '0;
    assign o_status.lead  = r_bcd[39:36];
    assign o_status.dig8  = r_bcd[35:32];
    assign o_x            = r_x;

endmodule

// File: rtl/sra_k_ctrl.sv
// ----------------------------------------------------------------------------
// sra_k_ctrl
// Sequencer for the passes and steps of the generator; it issues one
// datapath operation each cycle and counts the serial iterations.
// ----------------------------------------------------------------------------
module sra_k_ctrl
    import sra_k_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy,
    output logic    o_valid
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PCVT0 = 4'd1;
    localparam logic [3:0] S_PCVT  = 4'd2;
    localparam logic [3:0] S_PSET  = 4'd3;
    localparam logic [3:0] S_DISP  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_QINIT = 4'd6;
    localparam logic [3:0] S_QCVT  = 4'd7;
    localparam logic [3:0] S_PICK  = 4'd8;
    localparam logic [3:0] S_P99   = 4'd9;
    localparam logic [3:0] S_CVT   = 4'd10;
    localparam logic [3:0] S_BOP   = 4'd11;
    localparam logic [3:0] S_HORN  = 4'd12;
    localparam logic [3:0] S_NEXT  = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    localparam logic [6:0] MUL_LAST  = 7'd33;
    localparam logic [6:0] QCVT_LAST = 7'd67;
    localparam logic [6:0] CVT_LAST  = 7'd33;
    localparam logic [6:0] HORN_LAST = 7'd9;

    logic [3:0] r_state, n_state;
    logic [6:0] r_cnt, n_cnt;
    logic [3:0] r_step, n_step;
    logic [3:0] r_left, n_left;
    logic       r_first, n_first;
    logic       r_dpend, n_dpend;
    logic       r_swap, n_swap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_step  <= '0;
            r_left  <= '0;
            r_first <= 1'b0;
            r_dpend <= 1'b0;
            r_swap  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            r_left  <= n_left;
            r_first <= n_first;
            r_dpend <= n_dpend;
            r_swap  <= n_swap;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_step    = r_step;
        n_left    = r_left;
        n_first   = r_first;
        n_dpend   = r_dpend;
        n_swap    = r_swap;
        o_cmd.op   = OP_NOP;
        o_cmd.msel = MS_SQ;
        o_cmd.dsel = DS_E10;
        o_valid    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = OP_LOAD;
                    n_first  = 1'b1;
                    n_state  = S_PCVT0;
                end
            end
            S_PCVT0: begin
                o_cmd.op = OP_CVT_INIT;
                n_cnt    = '0;
                n_state  = S_PCVT;
            end
            S_PCVT: begin
                o_cmd.op = OP_CVT_STEP;
                n_cnt    = r_cnt + 7'd1;
                if (r_cnt == CVT_LAST) begin
                    n_state = S_PSET;
                end
            end
            S_PSET: begin
                if (r_first) begin
                    n_left  = i_status.lead;
                    n_first = 1'b0;
                end
                n_step  = i_status.dig8 + 4'd3;
                n_state = S_DISP;
            end
            S_DISP: begin
                n_cnt = '0;
                case (r_step) inside
                    4'd3: begin
                        o_cmd.op = OP_ADD5E9;
                        n_state  = S_NEXT;
                    end
                    4'd4: begin
                        o_cmd.op   = OP_MUL_INIT;
                        o_cmd.msel = MS_SQ;
                        n_dpend    = 1'b1;
                        n_state    = S_MUL;
                    end
                    4'd5, 4'd8: begin
                        o_cmd.op   = OP_MUL_INIT;
                        o_cmd.msel = MS_K;
                        n_dpend    = 1'b0;
                        n_state    = S_MUL;
                    end
                    4'd6: begin
                        o_cmd.op = OP_STEP6;
                        n_state  = S_NEXT;
                    end
                    4'd7, 4'd9: begin
                        o_cmd.op = OP_CVT_INIT;
                        n_swap   = (r_step == 4'd7);
                        n_state  = S_CVT;
                    end
                    4'd10: begin
                        if (i_status.lt_e5) begin
                            o_cmd.op   = OP_MUL_INIT;
                            o_cmd.msel = MS_SQ;
                            n_state    = S_MUL;
                        end else begin
                            o_cmd.op = OP_SUB99999;
                            n_state  = S_NEXT;
                        end
                    end
                    4'd11: begin
                        if (i_status.lt_e9 && !i_status.zero) begin
                            o_cmd.op = OP_MUL10;
                        end else begin
                            n_state = S_NEXT;
                        end
                    end
                    default: begin
                        if (i_status.zero) begin
                            n_state = S_NEXT;
                        end else begin
                            o_cmd.op   = OP_MUL_INIT;
                            o_cmd.msel = MS_SQM1;
                            n_dpend    = 1'b1;
                            n_state    = S_MUL;
                        end
                    end
                endcase
            end
            S_MUL: begin
                o_cmd.op = OP_MUL_STEP;
                n_cnt    = r_cnt + 7'd1;
                if (r_cnt == MUL_LAST) begin
                    n_state = (r_step == 4'd10) ? S_P99 : S_QINIT;
                end
            end
            S_QINIT: begin
                o_cmd.op = OP_QCVT_INIT;
                n_cnt    = '0;
                n_state  = S_QCVT;
            end
            S_QCVT: begin
                o_cmd.op = OP_CVT_STEP;
                n_cnt    = r_cnt + 7'd1;
                if (r_cnt == QCVT_LAST) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.op   = OP_PICK;
                o_cmd.dsel = r_dpend ? DS_E5 : DS_E10;
                n_cnt      = '0;
                n_state    = S_HORN;
            end
            S_P99: begin
                o_cmd.op = OP_TAKE_P99;
                n_state  = S_NEXT;
            end
            S_CVT: begin
                o_cmd.op = OP_CVT_STEP;
                n_cnt    = r_cnt + 7'd1;
                if (r_cnt == CVT_LAST) begin
                    n_state = S_BOP;
                end
            end
            S_BOP: begin
                o_cmd.op = r_swap ? OP_SWAP : OP_DECD;
                n_cnt    = '0;
                n_state  = S_HORN;
            end
            S_HORN: begin
                o_cmd.op = OP_HORN;
                n_cnt    = r_cnt + 7'd1;
                if (r_cnt == HORN_LAST) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_step == 4'd12) begin
                    if (r_left == 4'd0) begin
                        n_state = S_DONE;
                    end else begin
                        n_left  = r_left - 4'd1;
                        n_state = S_PCVT0;
                    end
                end else begin
                    n_step  = r_step + 4'd1;
                    n_state = S_DISP;
                end
            end
            S_DONE: begin
                o_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = r_state != S_IDLE;

endmodule

// File: rtl/superrandom_algorithm_k.sv
// ----------------------------------------------------------------------------
// superrandom_algorithm_k
// Super-random generator: one full run of the ten-digit algorithm per start.
// ----------------------------------------------------------------------------
// A value is taken when start is high while busy is low, and busy stays high
// until the result has been shown. The result appears on o_next_value for a
// single cycle with o_valid high and must be captured then, as it cannot be
// held off. The run length depends on the value: each pass starts with a
// decimal conversion and then runs its steps, each a rotate or digit decrement,
// a multiply by the constant or either middle square, the small square or one
// of the simple steps; a product goes through the bit-serial multiplier, a
// decimal conversion and a read-back of the wanted digits. A run takes up to
// ten full passes.
module superrandom_algorithm_k
    import sra_k_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic [W_X-1:0] i_start_value,
    output logic           busy,
    output logic           o_valid,
    output logic [W_X-1:0] o_next_value
);

    t_cmd    cmd;
    t_status status;

    sra_k_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_valid  (o_valid)
    );

    sra_k_datapath u_datapath (
        .i_clk         (i_clk),
        .i_start_value (i_start_value),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_x           (o_next_value)
    );

    a_valid_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("Result beat not followed by idle.");

    a_valid_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("Result beat outside a run.");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_next_value < C_E10))
        else $error("Result beat not below ten to the tenth.");

    a_start_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("Accepted beat did not start a run.");

endmodule
